### src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, inactive while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, inactive while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/cle_pkg.sv
package cle_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_PRINT,
    CLS_BS,
    CLS_EOL,
    CLS_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_READ
  } bk_state_e;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic [5:0] read_index;
    cls_e       cls;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [5:0] line_length;
    logic       ended_by_eol;
    logic       last;
  } res_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

### src/console_line_editor_core.sv
// flow: transactions wait in the input queue; the back end takes one when idle, and a
//   character then gives one result per cycle (up to 3) while the sink is ready; a read gives
//   its result from the line store through the BK_READ state; the back end takes no new item
//   until the back-end sequencer has emitted every result of the last one from its slot registers
// reset: asynchronous, active low; clears queue, line state and capacity (64); the line
//   store keeps its contents and needs no clearing pass
module console_line_editor_core #(
  parameter int LINE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // char_code[7:0], read_index[13:8], zero[15:14]
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_byte[7:0], line_length[13:8], ended_by_eol[14], zero[15]
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic [6:0]     cap_q;
  cle_pkg::item_t item;
  logic           item_valid;
  logic           item_pop;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  cle_pkg::res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cle_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  cle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  cle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .m_tvalid_o   (m_axis_tvalid),
    .m_res_o      (res),
    .m_tready_i   (m_axis_tready)
  );

  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = {1'b0, res.ended_by_eol, res.line_length, res.out_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

### src/cle_ram.sv
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/cle_front.sv
module cle_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  logic [15:0]    s_tdata_i,
  input  logic           s_tuser_i,
  output cle_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_pop_i
);

  cle_pkg::item_t q_mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  cle_pkg::item_t in_item;
  logic           push;
  logic           pop;

  function automatic cle_pkg::cls_e classify(logic [7:0] c);
    cle_pkg::cls_e r;
    if (cle_pkg::is_blank(c)) begin
      r = cle_pkg::CLS_BLANK;
    end else if (c >= cle_pkg::CH_SPACE && c <= cle_pkg::CH_TILDE) begin
      r = cle_pkg::CLS_PRINT;
    end else if (c == cle_pkg::CH_BS) begin
      r = cle_pkg::CLS_BS;
    end else if (c == cle_pkg::CH_CR || c == cle_pkg::CH_LF) begin
      r = cle_pkg::CLS_EOL;
    end else begin
      r = cle_pkg::CLS_OTHER;
    end
    return r;
  endfunction

  always_comb begin
    in_item.command    = s_tuser_i;
    in_item.char_code  = s_tdata_i[7:0];
    in_item.read_index = s_tdata_i[13:8];
    in_item.cls        = classify(s_tdata_i[7:0]);
  end

  assign s_tready_o   = (count_q != 2'd2);
  assign push         = s_tvalid_i && s_tready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

### src/cle_back.sv
module cle_back #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [6:0]                    cap_i,
  input  cle_pkg::item_t                item_i,
  input  logic                          item_valid_i,
  output logic                          item_pop_o,
  output logic                          ram_we_o,
  output logic [$clog2(LINE_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(LINE_DEPTH)-1:0] ram_raddr_o,
  input  logic [7:0]                    ram_rdata_i,
  output logic                          m_tvalid_o,
  output cle_pkg::res_t                 m_res_o,
  input  logic                          m_tready_i
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = (AW > 6) ? AW : 6;
  localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
  localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
  localparam logic [CW-1:0] TWO_C   = CW'(2);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [LW:0]   DEPTH_L = (LW + 1)'(LINE_DEPTH);
  localparam logic [AW-1:0] AONE    = AW'(1);

  cle_pkg::bk_state_e state_q, state_d;
  logic [AW-1:0]      wp_q, wp_d;
  logic               done_q, done_d;
  logic               prev_blank_q, prev_blank_d;
  logic               refresh_q, refresh_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [1:0]         emit_q, emit_d;
  logic               out_valid_q, out_valid_d;
  cle_pkg::res_t      out_q, out_d;
  cle_pkg::res_t      slot_q [3];
  cle_pkg::res_t      slot_d [3];
  logic               hit_q, hit_d;

  logic [CW-1:0] cap_w, cap_sat, limit_w;
  logic [AW-1:0] limit;
  logic [AW-1:0] wp_base;
  logic [LW-1:0] idx_w;
  logic          out_free;
  logic          pop;

  function automatic cle_pkg::res_t mk_res(cle_pkg::kind_e k, logic [7:0] b,
                                           logic [AW-1:0] len, logic eol);
    cle_pkg::res_t r;
    logic [LW-1:0] len_w;
    len_w          = LW'(len);
    r.kind         = k;
    r.out_byte     = b;
    r.line_length  = len_w[5:0];
    r.ended_by_eol = eol;
    r.last         = 1'b0;
    return r;
  endfunction

  // effective capacity saturates into the buffer range
  always_comb begin
    cap_w = CW'(cap_i);
    if (cap_w < TWO_C) begin
      cap_sat = TWO_C;
    end else if (cap_w > DEPTH_C) begin
      cap_sat = DEPTH_C;
    end else begin
      cap_sat = cap_w;
    end
    limit_w = cap_sat - ONE_C;
    limit   = limit_w[AW-1:0];
  end

  assign out_free = !out_valid_q || m_tready_i;
  assign idx_w    = LW'(item_i.read_index);
  assign wp_base  = done_q ? '0 : wp_q;

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    done_d       = done_q;
    prev_blank_d = prev_blank_q;
    refresh_d    = 1'b0;
    cnt_d        = cnt_q;
    emit_d       = emit_q;
    out_valid_d  = out_valid_q && !m_tready_i;
    out_d        = out_q;
    slot_d       = slot_q;
    hit_d        = hit_q;
    pop          = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = wp_base;
    ram_wdata_o  = item_i.char_code;
    ram_re_o     = 1'b0;
    ram_raddr_o  = idx_w[AW-1:0];

    // new last character after a backspace
    if (refresh_q) begin
      prev_blank_d = cle_pkg::is_blank(ram_rdata_i);
    end

    case (state_q)
      cle_pkg::BK_IDLE: begin
        if (item_valid_i) begin
          pop = 1'b1;
          if (item_i.command == cle_pkg::CMD_READ) begin
            ram_re_o = 1'b1;
            hit_d    = ({1'b0, idx_w} < DEPTH_L) && (idx_w < LW'(wp_q));
            state_d  = cle_pkg::BK_READ;
          end else begin
            cnt_d  = 2'd0;
            emit_d = 2'd0;
            wp_d   = wp_base;
            done_d = 1'b0;
            if (wp_base >= limit) begin
              slot_d[0] = mk_res(cle_pkg::KIND_LINE, 8'h00, wp_base, 1'b0);
              cnt_d     = 2'd1;
              done_d    = 1'b1;
            end else begin
              case (item_i.cls)
                cle_pkg::CLS_BLANK: begin
                  if (wp_base != '0 && !prev_blank_q) begin
                    slot_d[0]    = mk_res(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, '0, 1'b0);
                    cnt_d        = 2'd1;
                    ram_we_o     = 1'b1;
                    wp_d         = wp_base + AONE;
                    prev_blank_d = 1'b1;
                  end
                end
                cle_pkg::CLS_PRINT: begin
                  slot_d[0]    = mk_res(cle_pkg::KIND_ECHO, item_i.char_code, '0, 1'b0);
                  cnt_d        = 2'd1;
                  ram_we_o     = 1'b1;
                  wp_d         = wp_base + AONE;
                  prev_blank_d = 1'b0;
                end
                cle_pkg::CLS_BS: begin
                  if (wp_base != '0) begin
                    slot_d[0]   = mk_res(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, '0, 1'b0);
                    slot_d[1]   = mk_res(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, '0, 1'b0);
                    slot_d[2]   = mk_res(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, '0, 1'b0);
                    cnt_d       = 2'd3;
                    wp_d        = wp_base - AONE;
                    ram_raddr_o = wp_base - AONE - AONE;
                    if (wp_base > AONE) begin
                      ram_re_o  = 1'b1;
                      refresh_d = 1'b1;
                    end
                  end
                end
                cle_pkg::CLS_EOL: begin
                  slot_d[0] = mk_res(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, '0, 1'b0);
                  slot_d[1] = mk_res(cle_pkg::KIND_LINE, 8'h00, wp_base, 1'b1);
                  cnt_d     = 2'd2;
                  done_d    = 1'b1;
                end
                default: begin
                end
              endcase
              // stored character filled the line
              if (ram_we_o && (wp_base + AONE) >= limit) begin
                slot_d[1] = mk_res(cle_pkg::KIND_LINE, 8'h00, wp_base + AONE, 1'b0);
                cnt_d     = 2'd2;
                done_d    = 1'b1;
              end
            end
            if (cnt_d != 2'd0) begin
              slot_d[cnt_d - 2'd1].last = 1'b1;
              state_d                   = cle_pkg::BK_EMIT;
            end
          end
        end
      end
      cle_pkg::BK_EMIT: begin
        if (out_free) begin
          out_d       = slot_q[emit_q];
          out_valid_d = 1'b1;
          emit_d      = emit_q + 2'd1;
          if (emit_q == cnt_q - 2'd1) begin
            state_d = cle_pkg::BK_IDLE;
          end
        end
      end
      cle_pkg::BK_READ: begin
        if (out_free) begin
          out_d       = mk_res(cle_pkg::KIND_READ, hit_q ? ram_rdata_i : 8'h00, '0, 1'b0);
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = cle_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = cle_pkg::BK_IDLE;
      end
    endcase
  end

  assign item_pop_o = pop;
  assign m_tvalid_o = out_valid_q;
  assign m_res_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cle_pkg::BK_IDLE;
      wp_q         <= '0;
      done_q       <= 1'b0;
      prev_blank_q <= 1'b0;
      refresh_q    <= 1'b0;
      cnt_q        <= 2'd0;
      emit_q       <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      done_q       <= done_d;
      prev_blank_q <= prev_blank_d;
      refresh_q    <= refresh_d;
      cnt_q        <= cnt_d;
      emit_q       <= emit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    slot_q <= slot_d;
    hit_q  <= hit_d;
  end

endmodule

### src/cle_checker.sv
`include "assert_macros.svh"

module cle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a result waiting for the sink stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // only the three defined result kinds appear
  `ASSERT_IMPLY(a_kind_legal, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser == cle_pkg::KIND_ECHO || m_axis_tuser == cle_pkg::KIND_LINE || m_axis_tuser == cle_pkg::KIND_READ)

  // echo and read transactions carry no length and no end flag
  `ASSERT_IMPLY(a_no_len, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != cle_pkg::KIND_LINE, m_axis_tdata[15:8] == 8'h00)

  // a read and a line end always close their input's results
  `ASSERT_IMPLY(a_read_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == cle_pkg::KIND_READ, m_axis_tlast)

  `ASSERT_IMPLY(a_line_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == cle_pkg::KIND_LINE, m_axis_tlast && m_axis_tdata[7:0] == 8'h00)

endmodule

bind console_line_editor_core cle_checker u_cle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### dv/console_line_editor_core_tb.sv
`timescale 1ns / 100ps

module console_line_editor_core_tb;

  localparam int LINE_MAX      = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 80;
  localparam int MAX_CYCLES    = 200000;
  localparam int TOTAL_ITEMS   = 120;

  class echo_line_checker;
    cle_pkg::res_t pending_echoes[$];
    logic [7:0]    line_mem[LINE_MAX];
    int unsigned   fill_count;
    bit            line_closed;
    logic [6:0]    capacity_reg;
    int            error_count;
    int            accepted_items;

    function new();
      fill_count     = 0;
      line_closed    = 1'b0;
      capacity_reg   = cle_pkg::CAP_RESET;
      error_count    = 0;
      accepted_items = 0;
    endfunction

    function void report(string msg);
      if (error_count < 100) $display("ERROR @%0t: %s", $time, msg);
      error_count++;
    endfunction

    function void set_capacity(logic [6:0] value);
      capacity_reg = value;
    endfunction

    function int pending();
      return pending_echoes.size();
    endfunction

    function bit blank_char(logic [7:0] c);
      return (c == cle_pkg::CH_SPACE) || (c == cle_pkg::CH_TAB);
    endfunction

    function cle_pkg::res_t make_res(cle_pkg::kind_e k, logic [7:0] b, logic [5:0] len,
                                     logic eol);
      cle_pkg::res_t r;
      r.kind         = k;
      r.out_byte     = b;
      r.line_length  = len;
      r.ended_by_eol = eol;
      r.last         = 1'b0;
      return r;
    endfunction

    // works out the results of one accepted input transaction
    function void predict_echo(logic cmd, logic [7:0] ch, logic [5:0] idx);
      cle_pkg::res_t batch[3];
      cle_pkg::res_t r;
      int            n;
      int unsigned   cap_eff;
      int unsigned   lim;
      logic [7:0]    rd;
      n = 0;
      if (cmd == cle_pkg::CMD_READ) begin
        rd = (idx < fill_count) ? line_mem[idx] : 8'h00;
        batch[0] = make_res(cle_pkg::KIND_READ, rd, 6'd0, 1'b0);
        n = 1;
      end else begin
        cap_eff = capacity_reg;
        if (cap_eff < 2) cap_eff = 2;
        if (cap_eff > LINE_MAX) cap_eff = LINE_MAX;
        lim = cap_eff - 1;
        if (line_closed) begin
          fill_count  = 0;
          line_closed = 1'b0;
        end
        if (fill_count >= lim) begin
          // capacity dropped under a partial line: character is dropped
          batch[n] = make_res(cle_pkg::KIND_LINE, 8'h00, 6'(fill_count), 1'b0);
          n = n + 1;
          line_closed = 1'b1;
        end else if (blank_char(ch)) begin
          if (fill_count > 0 && !blank_char(line_mem[fill_count - 1])) begin
            batch[n] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, 6'd0, 1'b0);
            n = n + 1;
            line_mem[fill_count] = ch;
            fill_count++;
          end
        end else if (ch >= cle_pkg::CH_SPACE && ch <= cle_pkg::CH_TILDE) begin
          batch[n] = make_res(cle_pkg::KIND_ECHO, ch, 6'd0, 1'b0);
          n = n + 1;
          line_mem[fill_count] = ch;
          fill_count++;
        end else if (ch == cle_pkg::CH_BS) begin
          if (fill_count > 0) begin
            batch[0] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 6'd0, 1'b0);
            batch[1] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, 6'd0, 1'b0);
            batch[2] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 6'd0, 1'b0);
            n = 3;
            fill_count--;
          end
        end else if (ch == cle_pkg::CH_CR || ch == cle_pkg::CH_LF) begin
          batch[0] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 6'd0, 1'b0);
          batch[1] = make_res(cle_pkg::KIND_LINE, 8'h00, 6'(fill_count), 1'b1);
          n = 2;
          line_closed = 1'b1;
        end
        if (!line_closed && n > 0 && fill_count >= lim) begin
          batch[n] = make_res(cle_pkg::KIND_LINE, 8'h00, 6'(fill_count), 1'b0);
          n = n + 1;
          line_closed = 1'b1;
        end
      end
      for (int i = 0; i < n; i++) begin
        r = batch[i];
        r.last = (i == n - 1);
        pending_echoes.push_back(r);
      end
      accepted_items++;
    endfunction

    function void check_echo(logic [1:0] kind, logic [7:0] b, logic [5:0] len, logic eol,
                             logic last);
      cle_pkg::res_t e;
      if (pending_echoes.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h len %0d", kind, b, len));
        return;
      end
      e = pending_echoes.pop_front();
      if (kind !== e.kind)
        report($sformatf("kind %0d, expected %0d", kind, e.kind));
      if (b !== e.out_byte)
        report($sformatf("out_byte %02h, expected %02h", b, e.out_byte));
      if (len !== e.line_length)
        report($sformatf("line_length %0d, expected %0d", len, e.line_length));
      if (eol !== e.ended_by_eol)
        report($sformatf("ended_by_eol %0b, expected %0b", eol, e.ended_by_eol));
      if (last !== e.last)
        report($sformatf("last %0b, expected %0b", last, e.last));
    endfunction

    function void final_check();
      cle_pkg::res_t e;
      while (pending_echoes.size() != 0) begin
        e = pending_echoes.pop_front();
        report($sformatf("missing result kind %0d byte %02h", e.kind, e.out_byte));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // char_code[7:0], read_index[13:8], zero[15:14]
  logic        s_axis_tuser;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // out_byte[7:0], line_length[13:8], ended_by_eol[14], zero[15]
  logic [1:0]  m_axis_tuser;   // kind
  logic        m_axis_tlast;

  echo_line_checker sb;
  int          cycle_count;
  int          burst_left;
  bit          no_gaps;
  logic        hold_request;
  bit          hold_taken;
  int          hold_left;
  int unsigned rx_cycle;

  console_line_editor_core #(
    .LINE_DEPTH(LINE_MAX)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // both handshakes are sampled with their pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.predict_echo(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[13:8]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_echo(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tdata[14],
                      m_axis_tlast);
    end
  end

  // receiver: one long hold-off on request, otherwise a rotating stall pattern
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle >> 7) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ((rx_cycle % 32) < 24);
      endcase
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [5:0] idx);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, idx, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!no_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
                                                   $urandom_range(1, 8);
      end
    end
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_item(cle_pkg::CMD_CHAR, ch, 6'($urandom_range(0, 63)));
  endtask

  task automatic send_read(input logic [5:0] idx);
    send_item(cle_pkg::CMD_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    // characters without results may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_capacity(value);
  endtask

  // mostly well-formed text with edits, reads and some noise
  task automatic send_random_line();
    int len;
    int pick;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 66) : $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62)
        send_char(8'($urandom_range(8'h21, 8'h7e)));
      else if (pick < 74)
        send_char($urandom_range(0, 1) ? cle_pkg::CH_SPACE : cle_pkg::CH_TAB);
      else if (pick < 82)
        send_char(cle_pkg::CH_BS);
      else if (pick < 88)
        send_read(6'($urandom_range(0, 63)));
      else if (pick < 94)
        send_char(8'($urandom_range(0, 255)));
      else
        send_char(8'($urandom_range(0, 31)));
    end
    if ($urandom_range(0, 99) < 80)
      send_char($urandom_range(0, 1) ? cle_pkg::CH_CR : cle_pkg::CH_LF);
    repeat ($urandom_range(0, 3))
      send_read($urandom_range(0, 1) ? 6'($urandom_range(0, len)) : 6'($urandom_range(0, 63)));
  endtask

  initial begin
    int sel;
    int phase;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = cle_pkg::CMD_CHAR;
    m_axis_tready = 1'b0;
    hold_request  = 1'b0;
    hold_taken    = 1'b0;
    hold_left     = 0;
    rx_cycle      = 0;
    cycle_count   = 0;
    no_gaps       = 1'b0;
    burst_left    = 4;
    sb = new();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset capacity: blanks, ignored codes, edits, reads and both line ends
    send_char(cle_pkg::CH_SPACE);
    send_char(cle_pkg::CH_BS);
    send_char(8'h00);
    send_char(8'hff);
    send_char(8'h7f);
    send_char(8'h41);
    send_char(cle_pkg::CH_SPACE);
    send_char(cle_pkg::CH_TAB);
    send_char(cle_pkg::CH_TILDE);
    send_char(8'h21);
    send_char(cle_pkg::CH_BS);
    send_read(6'd0);
    send_read(6'd63);
    send_read(6'd2);
    send_char(cle_pkg::CH_CR);
    send_read(6'd0);
    send_char(cle_pkg::CH_LF);
    send_char(8'h78);
    send_char(cle_pkg::CH_TAB);
    send_read(6'd1);
    send_char(cle_pkg::CH_CR);

    // smallest capacity: every stored character completes the line
    wait_drained();
    write_capacity(7'd2);
    send_char(8'h61);
    send_char(8'h7a);
    send_char(cle_pkg::CH_BS);
    send_char(cle_pkg::CH_SPACE);
    send_char(8'h71);
    send_read(6'd0);
    send_read(6'd1);

    // out of range high saturates to the full store
    wait_drained();
    write_capacity(7'd127);
    repeat (63) send_char(8'($urandom_range(8'h21, 8'h7e)));
    send_read(6'd62);
    send_read(6'd63);
    send_char(8'h6b);

    // capacity lowered under a partial line
    wait_drained();
    write_capacity(7'd64);
    send_char(cle_pkg::CH_LF);
    repeat (10) send_char(8'($urandom_range(8'h21, 8'h7e)));
    wait_drained();
    write_capacity(7'd4);
    send_char(8'h6d);
    send_read(6'd9);
    send_char(8'h6e);

    wait_drained();
    write_capacity(7'd0);
    send_char(8'h78);
    send_read(6'd0);

    phase = 0;
    while (phase < 2 || sb.accepted_items < TOTAL_ITEMS) begin
      wait_drained();
      sel = $urandom_range(0, 9);
      if (phase == 1)
        write_capacity(7'd64);
      else if (sel == 0)
        write_capacity(7'($urandom_range(0, 127)));
      else if (sel == 1)
        write_capacity(7'd64);
      else if (sel == 2)
        write_capacity(7'd2);
      else
        write_capacity(7'($urandom_range(3, 12)));
      if (phase == 1) begin
        // receiver holds off while the sender keeps offering back to back
        hold_request <= 1'b1;
        no_gaps = 1'b1;
        repeat (20) send_char(8'($urandom_range(8'h21, 8'h7e)));
        no_gaps = 1'b0;
        send_char(cle_pkg::CH_CR);
        wait_drained();
      end
      repeat ($urandom_range(1, 3)) send_random_line();
      phase++;
    end

    wait_drained();
    sb.final_check();
    if (sb.error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/cle_pkg.sv
src/cle_ram.sv
src/cle_front.sv
src/cle_back.sv
src/console_line_editor_core.sv
src/cle_checker.sv
dv/console_line_editor_core_tb.sv
